/* hdl/assert_macros.svh */
// Shared assertion macros for the shifter checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hdl/smsu_pkg.sv */
package smsu_pkg;

  localparam int WORD_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int BYTE_BITS      = 8;
  localparam int HALF_BITS      = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 16;
  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 16;
  localparam int OUT_USED_BITS  = 4 + BYTE_BITS;

  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOCK_POLARITY     = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CLOCK_PHASE        = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LSB_FIRST          = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SELECT_ACTIVE_HIGH = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_HALF_PERIOD        = 3'd4;

  typedef enum logic [1:0] {
    OP_LOAD = 2'b01,
    OP_TICK = 2'b10
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [BYTE_BITS-1:0] tx_byte;
    logic                 last_byte;
    logic                 release_select;
    logic                 miso_level;
  } item_t;

endpackage

/* hdl/smsu_front.sv */
module smsu_front (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [smsu_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  input  logic                                q_full,
  output logic                                q_push,
  output smsu_pkg::item_t                     q_item
);
  import smsu_pkg::*;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // Classify the beat; clear the fields that its kind does not use.
  always_comb begin
    q_item = '0;
    if (s_tuser) begin
      q_item.op         = OP_TICK;
      q_item.miso_level = s_tdata[BYTE_BITS+1];
    end else begin
      q_item.op             = OP_LOAD;
      q_item.tx_byte        = s_tdata[BYTE_BITS-1:0];
      q_item.last_byte      = s_tlast;
      q_item.release_select = s_tdata[BYTE_BITS];
    end
  end

endmodule

/* hdl/smsu_queue.sv */
module smsu_queue #(
  parameter int DEPTH = smsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smsu_pkg::item_t wr_item,
  output logic            full,
  input  logic            pop,
  output logic            rd_valid,
  output smsu_pkg::item_t rd_item
);
  import smsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* hdl/smsu_back.sv */
module smsu_back #(
  parameter int WORD_BITS = smsu_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [smsu_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [smsu_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic                                 q_valid,
  input  smsu_pkg::item_t                      q_item,
  output logic                                 q_pop,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [smsu_pkg::OUT_DATA_BITS-1:0]   m_tdata,
  output logic                                 m_tuser
);
  import smsu_pkg::*;

  localparam int BL = $clog2(WORD_BITS + 1);

  logic                 clock_polarity;
  logic                 clock_phase;
  logic                 lsb_first;
  logic                 select_active_high;
  logic [HALF_BITS-1:0] half_period;

  logic [WORD_BITS-1:0] tx_shift, tx_shift_next;
  logic [WORD_BITS-1:0] rx_shift, rx_shift_next;
  logic [BL-1:0]        bits_left, bits_left_next;
  logic [HALF_BITS-1:0] tick_count, tick_count_next;
  logic                 edge_phase, edge_phase_next;
  logic                 clock_level, clock_level_next;
  logic                 selected, selected_next;
  logic [1:0]           end_flags, end_flags_next;
  logic                 mosi_pin, mosi_pin_next;
  logic                 rx_valid_next;
  logic [BYTE_BITS-1:0] rx_out_next;

  logic [WORD_BITS-1:0] load_word;
  logic [WORD_BITS-1:0] tx_adv;
  logic [WORD_BITS-1:0] rx_sampled;
  logic [HALF_BITS-1:0] tick_inc;
  logic [HALF_BITS-1:0] limit;
  logic [BL-1:0]        bits_dec;
  logic                 cur_bit;
  logic                 adv_bit;
  logic                 load_bit;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_polarity     <= 1'b0;
      clock_phase        <= 1'b0;
      lsb_first          <= 1'b0;
      select_active_high <= 1'b0;
      half_period        <= HALF_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLOCK_POLARITY:     clock_polarity     <= cfg_data[0];
        REG_CLOCK_PHASE:        clock_phase        <= cfg_data[0];
        REG_LSB_FIRST:          lsb_first          <= cfg_data[0];
        REG_SELECT_ACTIVE_HIGH: select_active_high <= cfg_data[0];
        REG_HALF_PERIOD:        half_period        <= cfg_data[HALF_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign load_word  = WORD_BITS'(q_item.tx_byte);
  assign tx_adv     = lsb_first ? (tx_shift >> 1) : (tx_shift << 1);
  assign rx_sampled = lsb_first ? {q_item.miso_level, rx_shift[WORD_BITS-1:1]}
                                : {rx_shift[WORD_BITS-2:0], q_item.miso_level};
  assign tick_inc   = tick_count + HALF_BITS'(1);
  assign limit      = (half_period == '0) ? HALF_BITS'(1) : half_period;
  assign bits_dec   = bits_left - BL'(1);
  assign cur_bit    = lsb_first ? tx_shift[0]  : tx_shift[WORD_BITS-1];
  assign adv_bit    = lsb_first ? tx_adv[0]    : tx_adv[WORD_BITS-1];
  assign load_bit   = lsb_first ? load_word[0] : load_word[WORD_BITS-1];

  always_comb begin
    tx_shift_next    = tx_shift;
    rx_shift_next    = rx_shift;
    bits_left_next   = bits_left;
    tick_count_next  = tick_count;
    edge_phase_next  = edge_phase;
    clock_level_next = clock_level;
    selected_next    = selected;
    end_flags_next   = end_flags;
    mosi_pin_next    = mosi_pin;
    rx_valid_next    = 1'b0;
    rx_out_next      = '0;
    case (q_item.op)
      OP_LOAD: begin
        if (bits_left == '0) begin
          tx_shift_next    = load_word;
          rx_shift_next    = '0;
          bits_left_next   = BL'(WORD_BITS);
          tick_count_next  = '0;
          edge_phase_next  = 1'b0;
          end_flags_next   = {q_item.release_select, q_item.last_byte};
          selected_next    = 1'b1;
          clock_level_next = clock_polarity;
          if (!clock_phase) begin
            mosi_pin_next = load_bit;
          end
        end
      end
      OP_TICK: begin
        if (bits_left != '0) begin
          if (tick_inc >= limit) begin
            tick_count_next = '0;
            if (!edge_phase) begin
              clock_level_next = !clock_polarity;
              if (!clock_phase) begin
                rx_shift_next = rx_sampled;
              end else begin
                mosi_pin_next = cur_bit;
                tx_shift_next = tx_adv;
              end
              edge_phase_next = 1'b1;
            end else begin
              clock_level_next = clock_polarity;
              if (clock_phase) begin
                rx_shift_next = rx_sampled;
              end
              bits_left_next = bits_dec;
              if (!clock_phase) begin
                tx_shift_next = tx_adv;
                if (bits_dec != '0) begin
                  mosi_pin_next = adv_bit;
                end
              end
              edge_phase_next = 1'b0;
              if (bits_dec == '0) begin
                rx_valid_next = 1'b1;
                rx_out_next   = BYTE_BITS'(rx_shift_next);
                if (end_flags == 2'b11) begin
                  selected_next = 1'b0;
                end
              end
            end
          end else begin
            tick_count_next = tick_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift    <= '0;
      rx_shift    <= '0;
      bits_left   <= '0;
      tick_count  <= '0;
      edge_phase  <= 1'b0;
      clock_level <= 1'b0;
      selected    <= 1'b0;
      end_flags   <= '0;
      mosi_pin    <= 1'b0;
    end else if (q_pop) begin
      tx_shift    <= tx_shift_next;
      rx_shift    <= rx_shift_next;
      bits_left   <= bits_left_next;
      tick_count  <= tick_count_next;
      edge_phase  <= edge_phase_next;
      clock_level <= clock_level_next;
      selected    <= selected_next;
      end_flags   <= end_flags_next;
      mosi_pin    <= mosi_pin_next;
    end else if (cfg_we && cfg_index == REG_CLOCK_POLARITY && bits_left == '0) begin
      clock_level <= cfg_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_tdata <= {{(OUT_DATA_BITS - OUT_USED_BITS){1'b0}},
                  (bits_left_next != '0),
                  rx_out_next,
                  (select_active_high ? selected_next : !selected_next),
                  mosi_pin_next,
                  clock_level_next};
      m_tuser <= rx_valid_next;
    end
  end

endmodule

/* hdl/spi_master_shifter_unit.sv */
// SPI master shifter, modes 0 to 3, MSB or LSB first. Each input beat is a load
// (tuser 0) or a tick (tuser 1); every beat yields exactly one result beat with
// the SCK, MOSI and chip select levels, and the received word flagged by tuser
// when it completes. One beat per clock is sustained in both directions: the
// front end classifies a beat into a QUEUE_DEPTH-entry queue in the cycle it
// arrives, and the shift engine retires one queued beat per clock into the
// output register whenever that register is empty or being taken. s_tready drops
// only when the queue is full. An SCK edge occurs every half_period tick beats;
// a load while a word is still shifting is ignored. Write configuration only
// with no beats in flight.
module spi_master_shifter_unit #(
  parameter int WORD_BITS   = smsu_pkg::WORD_BITS_DEF,
  parameter int QUEUE_DEPTH = smsu_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] tx_byte, [8] release_select, [9] miso_level, [15:10] zero
  input  logic [smsu_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // [0] command
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [0] sck_level, [1] mosi_level, [2] select_level, [10:3] rx_byte,
  // [11] busy_res, [15:12] zero
  output logic [smsu_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  // [0] rx_valid
  output logic                                m_tuser,
  input  logic                                cfg_we,
  input  logic [smsu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smsu_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import smsu_pkg::*;

  item_t front_item;
  item_t back_item;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;

  smsu_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (front_item)
  );

  smsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_item  (front_item),
    .full     (q_full),
    .pop      (q_pop),
    .rd_valid (q_valid),
    .rd_item  (back_item)
  );

  smsu_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (back_item),
    .q_pop     (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

/* hdl/smsu_checker.sv */
`include "assert_macros.svh"

module smsu_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [smsu_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input logic                                m_tuser
);
  import smsu_pkg::*;

  // Hold a stalled result beat.
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
               m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // A completed word leaves the shifter idle.
  `ASSERT_IMPLY(a_done_not_busy, clk, rst, m_tvalid && m_tuser,
                !m_tdata[BYTE_BITS+3])

  // Drive the received word as zero unless it is flagged.
  `ASSERT_IMPLY(a_rx_zero, clk, rst, m_tvalid && !m_tuser,
                m_tdata[BYTE_BITS+2:3] == '0)

  // Drop any result beat after reset.
  `ASSERT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind spi_master_shifter_unit smsu_checker u_checker (.*);
